// ----- rtl/core/full_convolution_fir_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the full convolution FIR unit
// Clocked implication checks with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef FULL_CONVOLUTION_FIR_UNIT_MACROS_SVH
`define FULL_CONVOLUTION_FIR_UNIT_MACROS_SVH

// Same-cycle implication.
`define FCF_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FCF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/fcf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcf_pkg
// Shared widths, codes and control types of the full convolution FIR unit.
// ----------------------------------------------------------------------------
package fcf_pkg;

    localparam int VALUE_BITS     = 16;
    localparam int TAP_INDEX_BITS = 4;
    localparam int SUM_BITS       = 36;
    localparam int CFG_BITS       = 5;

    localparam int IN_TDATA_BITS  = ((TAP_INDEX_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((SUM_BITS + 7) / 8) * 8;

    typedef enum logic {
        FUNC_LOAD   = 1'b0,
        FUNC_SAMPLE = 1'b1
    } func_t;

    // Control broadcast to every cell of the row.
    typedef struct packed {
        logic                      shift;
        logic                      clear;
        logic                      prod_en;
        logic                      coef_we;
        logic [TAP_INDEX_BITS-1:0] coef_idx;
    } cell_ctrl_t;

endpackage

// ----- rtl/core/fcf_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcf_cell
// One tap: holds a coefficient and one delay-line sample, multiplies its
// coefficient by the sample handed in from the left, passes its sample right.
// ----------------------------------------------------------------------------
module fcf_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int TAP_BITS    = 5,
    parameter int IDX         = 0
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  fcf_pkg::cell_ctrl_t                  ctrl,
    input  logic [TAP_BITS-1:0]                  taps,
    input  logic signed [SAMPLE_BITS-1:0]        coef_wdata,
    input  logic signed [SAMPLE_BITS-1:0]        op_in,
    output logic signed [SAMPLE_BITS-1:0]        op_out,
    output logic signed [fcf_pkg::SUM_BITS-1:0]  prod_out
);
    import fcf_pkg::*;

    logic signed [SAMPLE_BITS-1:0]   coef_reg;
    logic signed [SAMPLE_BITS-1:0]   samp_reg;
    logic signed [SUM_BITS-1:0]      prod_reg;
    logic signed [SUM_BITS-1:0]      prod_next;
    logic signed [2*SAMPLE_BITS-1:0] prod_full;
    logic                            in_use;

    assign prod_full = coef_reg * op_in;
    assign in_use    = TAP_BITS'(IDX) < taps;
    assign prod_next = in_use ? SUM_BITS'(prod_full) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
            samp_reg <= '0;
        end else begin
            if (ctrl.coef_we && (int'(ctrl.coef_idx) == IDX)) begin
                coef_reg <= coef_wdata;
            end
            // end of frame empties the line, even on the cycle it shifts
            if (ctrl.clear) begin
                samp_reg <= '0;
            end else if (ctrl.shift) begin
                samp_reg <= op_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.prod_en) begin
            prod_reg <= prod_next;
        end
    end

    assign op_out   = samp_reg;
    assign prod_out = prod_reg;

endmodule

// ----- rtl/core/fcf_sum_tree.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcf_sum_tree
// Registered binary adder tree with one register per level and a valid/ready
// chain, so bubbles collapse and the output register acts as the skid stage.
// ----------------------------------------------------------------------------
module fcf_sum_tree #(
    parameter int N = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    input  logic                                 in_last,
    input  logic signed [fcf_pkg::SUM_BITS-1:0]  in_data [N],
    output logic                                 in_ready,
    output logic                                 out_valid,
    output logic                                 out_last,
    output logic signed [fcf_pkg::SUM_BITS-1:0]  out_data,
    input  logic                                 out_ready
);
    import fcf_pkg::*;

    localparam int L = $clog2(N);
    localparam int P = 1 << L;

    logic signed [SUM_BITS-1:0] leaf [P];
    logic signed [SUM_BITS-1:0] node_reg [1:P-1];

    logic [L+1:1] rdy;
    logic [L:1]   v_in;
    logic [L:1]   last_in;
    logic [L:1]   v_reg;
    logic [L:1]   v_next;
    logic [L:1]   last_reg;
    logic [L:1]   last_next;

    for (genvar i = 0; i < P; i++) begin : g_leaf
        if (i < N) begin : g_used
            assign leaf[i] = in_data[i];
        end else begin : g_pad
            assign leaf[i] = '0;
        end
    end

    // node i sits at depth clog2(i+1)-1; nodes just above the leaves are level 1
    for (genvar i = 1; i < P; i++) begin : g_node
        localparam int LVL = L - ($clog2(i + 1) - 1);
        logic signed [SUM_BITS-1:0] lhs;
        logic signed [SUM_BITS-1:0] rhs;
        if (2 * i >= P) begin : g_from_leaf
            assign lhs = leaf[2 * i - P];
            assign rhs = leaf[2 * i + 1 - P];
        end else begin : g_from_node
            assign lhs = node_reg[2 * i];
            assign rhs = node_reg[2 * i + 1];
        end
        always_ff @(posedge aclk) begin
            if (rdy[LVL]) begin
                node_reg[i] <= lhs + rhs;
            end
        end
    end

    always_comb begin
        rdy[L+1]   = out_ready;
        v_in[1]    = in_valid;
        last_in[1] = in_last;
        for (int s = 2; s <= L; s++) begin
            v_in[s]    = v_reg[s-1];
            last_in[s] = last_reg[s-1];
        end
        for (int s = L; s >= 1; s--) begin
            rdy[s] = !v_reg[s] || rdy[s+1];
        end
        for (int s = 1; s <= L; s++) begin
            v_next[s]    = rdy[s] ? v_in[s] : v_reg[s];
            last_next[s] = rdy[s] ? last_in[s] : last_reg[s];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg    <= '0;
            last_reg <= '0;
        end else begin
            v_reg    <= v_next;
            last_reg <= last_next;
        end
    end

    assign in_ready  = rdy[1];
    assign out_valid = v_reg[L];
    assign out_last  = last_reg[L];
    assign out_data  = node_reg[1];

endmodule

// ----- rtl/core/full_convolution_fir_unit.sv -----
`timescale 1ns / 1ps
// Pipeline: $clog2(MAX_TAPS)+1 register stages (5 by default): the cell product registers,
//   then one per adder-tree level. A sample's products load at the edge that accepts it, and
//   its sum reaches m_tdata after the last adder-tree level.
// Throughput: one item per cycle unless m_tready stalls; a last sample adds taps_eff-1 issues
//   of zeros through the same cell row, while s_tready stays low. Load items produce no result.
// Reset (aresetn low, synchronous): tap_count to 1; coefficients, delay line, valids cleared.
// ----------------------------------------------------------------------------
// full_convolution_fir_unit
// Streaming full-padding 1D convolution over a row of multiply cells with a
// pipelined adder tree; a frame's last sample triggers the zero-fed tail.
// ----------------------------------------------------------------------------
module full_convolution_fir_unit #(
    parameter int MAX_TAPS    = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [fcf_pkg::CFG_BITS-1:0]          cfg_wdata,   // tap_count
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [fcf_pkg::IN_TDATA_BITS-1:0]     s_tdata,     // tap_index[3:0], value[19:4]
    input  logic                                  s_tuser,     // func
    input  logic                                  s_tlast,     // last_sample
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [fcf_pkg::OUT_TDATA_BITS-1:0]    m_tdata,     // sum[35:0]
    output logic                                  m_tlast      // last_of_frame
);
    import fcf_pkg::*;

    `include "full_convolution_fir_unit_macros.svh"

    localparam int TAP_BITS = $clog2(MAX_TAPS + 1);
    localparam int CNT_BITS = $clog2(MAX_TAPS);

    logic [CFG_BITS-1:0]          tap_count_reg;
    logic [TAP_BITS-1:0]          taps_eff;
    logic [CNT_BITS-1:0]          tail_cnt_reg;
    logic [CNT_BITS-1:0]          tail_cnt_next;
    logic                         v0_reg;
    logic                         v0_next;
    logic                         last0_reg;
    logic                         last0_next;

    logic                         tail_active;
    logic                         ready0;
    logic                         tree_ready;
    logic                         s_acc;
    logic                         samp_acc;
    logic                         load_acc;
    logic                         tail_issue;
    logic                         issue;
    logic                         issue_final;
    func_t                        in_func;

    logic signed [VALUE_BITS-1:0]  in_value;
    logic signed [SAMPLE_BITS-1:0] x_conv;
    logic signed [SAMPLE_BITS-1:0] op [MAX_TAPS+1];
    logic signed [SUM_BITS-1:0]    prod [MAX_TAPS];
    logic signed [SUM_BITS-1:0]    sum;
    cell_ctrl_t                    ctrl;

    assign in_func  = func_t'(s_tuser);
    assign in_value = $signed(s_tdata[TAP_INDEX_BITS +: VALUE_BITS]);
    assign x_conv   = SAMPLE_BITS'(in_value);

    always_comb begin
        if (tap_count_reg == '0) begin
            taps_eff = TAP_BITS'(1);
        end else if (int'(tap_count_reg) > MAX_TAPS) begin
            taps_eff = TAP_BITS'(MAX_TAPS);
        end else begin
            taps_eff = TAP_BITS'(tap_count_reg);
        end
    end

    assign tail_active = tail_cnt_reg != '0;
    assign ready0      = !v0_reg || tree_ready;
    assign s_tready    = ready0 && !tail_active;
    assign s_acc       = s_tvalid && s_tready;
    assign samp_acc    = s_acc && (in_func == FUNC_SAMPLE);
    assign load_acc    = s_acc && (in_func == FUNC_LOAD);
    assign tail_issue  = tail_active && ready0;
    assign issue       = samp_acc || tail_issue;
    assign issue_final = (samp_acc && s_tlast && (taps_eff == TAP_BITS'(1)))
                      || (tail_issue && (tail_cnt_reg == CNT_BITS'(1)));

    always_comb begin
        tail_cnt_next = tail_cnt_reg;
        if (samp_acc && s_tlast) begin
            tail_cnt_next = CNT_BITS'(taps_eff - TAP_BITS'(1));
        end else if (tail_issue) begin
            tail_cnt_next = tail_cnt_reg - CNT_BITS'(1);
        end
        v0_next    = ready0 ? issue : v0_reg;
        last0_next = ready0 ? issue_final : last0_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg <= CFG_BITS'(1);
            tail_cnt_reg  <= '0;
            v0_reg        <= 1'b0;
            last0_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                tap_count_reg <= cfg_wdata;
            end
            tail_cnt_reg <= tail_cnt_next;
            v0_reg       <= v0_next;
            last0_reg    <= last0_next;
        end
    end

    always_comb begin
        ctrl.shift    = issue;
        ctrl.clear    = issue && issue_final;
        ctrl.prod_en  = ready0;
        ctrl.coef_we  = load_acc;
        ctrl.coef_idx = s_tdata[TAP_INDEX_BITS-1:0];
    end

    // tail cycles feed zeros into the head of the row
    assign op[0] = samp_acc ? x_conv : '0;

    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
        fcf_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .TAP_BITS    (TAP_BITS),
            .IDX         (k)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .taps       (taps_eff),
            .coef_wdata (x_conv),
            .op_in      (op[k]),
            .op_out     (op[k+1]),
            .prod_out   (prod[k])
        );
    end

    fcf_sum_tree #(
        .N (MAX_TAPS)
    ) u_tree (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v0_reg),
        .in_last   (last0_reg),
        .in_data   (prod),
        .in_ready  (tree_ready),
        .out_valid (m_tvalid),
        .out_last  (m_tlast),
        .out_data  (sum),
        .out_ready (m_tready)
    );

    assign m_tdata = OUT_TDATA_BITS'($unsigned(sum));

    `FCF_ASSERT_NOW(a_tail_blocks_input, aclk, aresetn, tail_active, !s_tready, "input taken during tail")
    `FCF_ASSERT_NEXT(a_final_ends_tail, aclk, aresetn, issue && issue_final, tail_cnt_reg == '0, "tail left running after frame end")
    `FCF_ASSERT_NEXT(a_last_starts_tail, aclk, aresetn, samp_acc && s_tlast && (taps_eff != TAP_BITS'(1)), tail_cnt_reg != '0, "no tail after last sample")

endmodule
